/* rtl/pressure_temperature_compensation_top_assert.svh */
// assertion macros shared by the compensation rtl
// no dependencies; real checks only when SYNTHESIS is not defined
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/ptc_pkg.sv */
// shared types and constants for the pressure/temperature compensation block
// no dependencies
package ptc_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [1:0] CFG_GROUP_A = 2'd0;
    localparam logic [1:0] CFG_GROUP_B = 2'd1;
    localparam logic [1:0] CFG_GROUP_C = 2'd2;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
    } out_item_t;

    typedef struct packed {
        logic [63:0] group_c;
        logic [63:0] group_b;
        logic [63:0] group_a;
    } cal_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } queue_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_V1,
        ST_D2,
        ST_V2,
        ST_TEMP,
        ST_AA,
        ST_B6,
        ST_B5,
        ST_A3,
        ST_A2,
        ST_A1,
        ST_NUM,
        ST_DIV,
        ST_C9A,
        ST_C9B,
        ST_C8
    } state_t;

endpackage

/* rtl/ptc_front.sv */
// front end: accepts items and holds them in a short queue for the back end
// depends on ptc_pkg
module ptc_front
    import ptc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  in_item_t   sample,
    output logic       busy,
    output queue_out_t head,
    input  logic       pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    in_item_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               do_pop;

    assign busy   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= sample;
        end
    end

endmodule

/* rtl/ptc_mul.sv */
// 64x64 multiply modulo 2^64 through one 32x32 multiplier
// depends on ptc_pkg
module ptc_mul
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        busy,
    output logic        done,
    output logic [63:0] product
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] pp;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            2'd1:    begin mx = a_reg[31:0];  my = b_reg[63:32]; end
            default: begin mx = a_reg[63:32]; my = b_reg[31:0];  end
        endcase
        pp = 64'(mx) * 64'(my);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        else if (busy_reg)
        begin
            case (cnt_reg)
                2'd0:    prod_reg <= pp;
                2'd1:
                begin
                    acc_reg  <= prod_reg;
                    prod_reg <= pp;
                end
                2'd2:
                begin
                    acc_reg  <= acc_reg + {prod_reg[31:0], 32'b0};
                    prod_reg <= pp;
                end
                default: acc_reg <= acc_reg + {prod_reg[31:0], 32'b0};
            endcase
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* rtl/ptc_div.sv */
// signed 64-bit divide truncating toward zero, one quotient bit per cycle
// depends on ptc_pkg
module ptc_div
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quot
);

    logic [63:0] q_reg;
    logic [63:0] r_reg;
    logic [63:0] d_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] rs;
    logic        ge;

    assign rs = {r_reg[62:0], q_reg[63]};
    assign ge = (rs >= d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[63] ? (64'd0 - num) : num;
            d_reg   <= den[63] ? (64'd0 - den) : den;
            r_reg   <= '0;
            neg_reg <= num[63] ^ den[63];
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? (rs - d_reg) : rs;
            q_reg <= {q_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (64'd0 - q_reg) : q_reg;

endmodule

/* rtl/ptc_back.sv */
// back end: sequences the compensation over the shared multiplier and divider
// depends on ptc_pkg, ptc_mul, ptc_div and the assertion macro header
`include "pressure_temperature_compensation_top_assert.svh"
module ptc_back
    import ptc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cal_t       cal,
    input  queue_out_t head,
    output logic       pop,
    output logic       done,
    output out_item_t  result
);

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    state_t             state_reg, state_next;
    logic               pend_reg, pend_next;
    logic               done_reg;
    out_item_t          result_reg;
    logic [19:0]        adc_t_reg;
    logic [19:0]        adc_p_reg;
    logic [63:0]        v1_reg;
    logic [63:0]        x_reg;
    logic [31:0]        tf_reg;
    logic signed [15:0] temp_reg;
    logic [63:0]        a_reg;
    logic [63:0]        aa_reg;
    logic [63:0]        b_reg;
    logic [63:0]        den_reg;
    logic [63:0]        num_reg;
    logic [63:0]        p_reg;
    logic [63:0]        c1_reg;

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] d1, d2, ps, praw, mul_a, mul_b, mul_p, div_q, psum, pres;
    logic        mul_start, mul_busy, mul_done, div_start, div_done;
    logic        is_mul, finish_ok, finish_bad;
    logic signed [34:0] t5;
    logic signed [26:0] tsh;
    logic signed [15:0] tsat;

    assign t1 = {48'b0, cal.group_a[15:0]};
    assign t2 = sx16(cal.group_a[31:16]);
    assign t3 = sx16(cal.group_a[47:32]);
    assign p1 = {48'b0, cal.group_a[63:48]};
    assign p2 = sx16(cal.group_b[15:0]);
    assign p3 = sx16(cal.group_b[31:16]);
    assign p4 = sx16(cal.group_b[47:32]);
    assign p5 = sx16(cal.group_b[63:48]);
    assign p6 = sx16(cal.group_c[15:0]);
    assign p7 = sx16(cal.group_c[31:16]);
    assign p8 = sx16(cal.group_c[47:32]);
    assign p9 = sx16(cal.group_c[63:48]);

    assign d1   = {47'b0, adc_t_reg[19:3]} - {47'b0, t1[15:0], 1'b0};
    assign d2   = {48'b0, adc_t_reg[19:4]} - t1;
    assign ps   = 64'($signed(p_reg) >>> 13);
    assign praw = 64'd1048576 - {44'b0, adc_p_reg};
    assign psum = p_reg + c1_reg + 64'($signed(mul_p) >>> 19);
    assign pres = 64'($signed(psum) >>> 8) + {p7[59:0], 4'b0};

    assign t5  = {{3{tf_reg[31]}}, tf_reg} + {tf_reg[31], tf_reg, 2'b0} + 35'sd128;
    assign tsh = 27'(t5 >>> 8);
    always_comb
    begin
        if (tsh > 27'sd32767)
        begin
            tsat = 16'sd32767;
        end
        else if (tsh < -27'sd32768)
        begin
            tsat = -16'sd32768;
        end
        else
        begin
            tsat = tsh[15:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        pop        = 1'b0;
        is_mul     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        finish_ok  = 1'b0;
        finish_bad = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    state_next = ST_V1;
                end
            end
            ST_V1:   begin is_mul = 1'b1; mul_a = d1; mul_b = t2; end
            ST_D2:   begin is_mul = 1'b1; mul_a = d2; mul_b = d2; end
            ST_V2:   begin is_mul = 1'b1; mul_a = x_reg; mul_b = t3; end
            ST_TEMP: state_next = ST_AA;
            ST_AA:   begin is_mul = 1'b1; mul_a = a_reg; mul_b = a_reg; end
            ST_B6:   begin is_mul = 1'b1; mul_a = aa_reg; mul_b = p6; end
            ST_B5:   begin is_mul = 1'b1; mul_a = a_reg; mul_b = p5; end
            ST_A3:   begin is_mul = 1'b1; mul_a = aa_reg; mul_b = p3; end
            ST_A2:   begin is_mul = 1'b1; mul_a = a_reg; mul_b = p2; end
            ST_A1:
            begin
                is_mul = 1'b1;
                mul_a  = 64'h0000_8000_0000_0000 + x_reg;
                mul_b  = p1;
            end
            ST_NUM:
            begin
                is_mul = 1'b1;
                mul_a  = {praw[32:0], 31'b0} - b_reg;
                mul_b  = 64'd3125;
            end
            ST_DIV:
            begin
                if (!pend_reg)
                begin
                    if (den_reg == '0)
                    begin
                        finish_bad = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        pend_next = 1'b1;
                    end
                end
                else if (div_done)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_C9A;
                end
            end
            ST_C9A:  begin is_mul = 1'b1; mul_a = p9; mul_b = ps; end
            ST_C9B:  begin is_mul = 1'b1; mul_a = x_reg; mul_b = ps; end
            ST_C8:   begin is_mul = 1'b1; mul_a = p8; mul_b = p_reg; end
        endcase
        mul_start = is_mul && !pend_reg;
        if (is_mul)
        begin
            if (mul_start)
            begin
                pend_next = 1'b1;
            end
            else if (mul_done)
            begin
                pend_next  = 1'b0;
                state_next = (state_reg == ST_C8) ? ST_IDLE : state_t'(state_reg + 1'b1);
                finish_ok  = (state_reg == ST_C8);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= finish_ok || finish_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    adc_t_reg <= head.item.raw_temperature;
                    adc_p_reg <= head.item.raw_pressure;
                end
            end
            ST_V1:   if (mul_done) v1_reg <= 64'($signed(mul_p) >>> 11);
            ST_D2:   if (mul_done) x_reg <= 64'($signed(mul_p) >>> 12);
            ST_V2:   if (mul_done) tf_reg <= 32'(v1_reg + 64'($signed(mul_p) >>> 14));
            ST_TEMP:
            begin
                temp_reg <= tsat;
                a_reg    <= {{32{tf_reg[31]}}, tf_reg} - 64'd128000;
            end
            ST_AA:   if (mul_done) aa_reg <= mul_p;
            ST_B6:   if (mul_done) b_reg <= mul_p;
            ST_B5:
            begin
                if (mul_done)
                begin
                    b_reg <= b_reg + {mul_p[46:0], 17'b0} + {p4[28:0], 35'b0};
                end
            end
            ST_A3:   if (mul_done) x_reg <= 64'($signed(mul_p) >>> 8);
            ST_A2:   if (mul_done) x_reg <= x_reg + {mul_p[51:0], 12'b0};
            ST_A1:   if (mul_done) den_reg <= 64'($signed(mul_p) >>> 33);
            ST_NUM:  if (mul_done) num_reg <= mul_p;
            ST_DIV:  if (div_done) p_reg <= div_q;
            ST_C9A:  if (mul_done) x_reg <= mul_p;
            ST_C9B:  if (mul_done) c1_reg <= 64'($signed(mul_p) >>> 25);
            ST_C8:   ;
        endcase
        if (finish_ok)
        begin
            result_reg.temperature_centi <= temp_reg;
            result_reg.pressure_q24_8    <= pres[31:0];
            result_reg.pressure_valid    <= 1'b1;
        end
        else if (finish_bad)
        begin
            result_reg.temperature_centi <= temp_reg;
            result_reg.pressure_q24_8    <= '0;
            result_reg.pressure_valid    <= 1'b0;
        end
    end

    ptc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    ptc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign done   = done_reg;
    assign result = result_reg;

    `PTC_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "result strobe held")
    `PTC_ASSERT_IMPL(a_mul_idle, clk, rst_n, mul_start, !mul_busy, "multiply started while busy")
    `PTC_ASSERT_IMPL(a_div_nonzero, clk, rst_n, div_start, den_reg != '0, "divide by zero started")
    `PTC_ASSERT_IMPL(a_pop_idle, clk, rst_n, pop, state_reg == ST_IDLE, "item taken mid-run")

endmodule

/* rtl/pressure_temperature_compensation_top.sv */
// top level of the pressure/temperature compensation block: calibration registers
// depends on ptc_pkg, ptc_front, ptc_back
//
// An item is taken when start is high and busy is low; up to QUEUE_DEPTH items wait
// in the input queue while one is computed. Each item uses thirteen 64-bit multiplies
// on one shared 32x32 multiplier and a radix-2 divider. A zero divisor skips the
// divide and the last three multiplies.
// The result shows for exactly one cycle with done high and must be taken then.
module pressure_temperature_compensation_top
    import ptc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    sample,
    output logic        done,
    output out_item_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cal_t       cal_reg;
    queue_out_t head;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GROUP_A: cal_reg.group_a <= cfg_data;
                CFG_GROUP_B: cal_reg.group_b <= cfg_data;
                CFG_GROUP_C: cal_reg.group_c <= cfg_data;
                default:     ;
            endcase
        end
    end

    ptc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sample (sample),
        .busy   (busy),
        .head   (head),
        .pop    (pop)
    );

    ptc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cal    (cal_reg),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

/* tb/tb_pressure_temperature_compensation_top.sv */
// testbench for the pressure/temperature compensation block: directed and random samples
// under several calibration settings, checked against a 64-bit integer predictor
// depends on ptc_pkg and pressure_temperature_compensation_top
module tb_pressure_temperature_compensation_top;
    import ptc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class comp_scoreboard;
        logic [63:0] grp_a, grp_b, grp_c;
        out_item_t   pending[$];
        int          errors;

        function new();
            grp_a = '0;
            grp_b = '0;
            grp_c = '0;
            errors = 0;
        endfunction

        function logic signed [63:0] cw(logic [63:0] r, int k);
            logic [15:0] w;
            w = r[16*k +: 16];
            return {{48{w[15]}}, w};
        endfunction

        function out_item_t compensate(in_item_t s);
            logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] d1, v1, d2, v2, tf, t, a, b, p, ps, c1, c2, num, ma, mb, q;
            out_item_t r;
            t1 = {48'd0, grp_a[15:0]};
            t2 = cw(grp_a, 1);
            t3 = cw(grp_a, 2);
            p1 = {48'd0, grp_a[63:48]};
            p2 = cw(grp_b, 0);
            p3 = cw(grp_b, 1);
            p4 = cw(grp_b, 2);
            p5 = cw(grp_b, 3);
            p6 = cw(grp_c, 0);
            p7 = cw(grp_c, 1);
            p8 = cw(grp_c, 2);
            p9 = cw(grp_c, 3);
            d1 = $signed({44'd0, s.raw_temperature} >> 3) - (t1 <<< 1);
            v1 = (d1 * t2) >>> 11;
            d2 = $signed({44'd0, s.raw_temperature} >> 4) - t1;
            v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
            tf = v1 + v2;
            tf = {{32{tf[31]}}, tf[31:0]};
            t = (tf * 5 + 128) >>> 8;
            if (t < -32768)
                t = -32768;
            else if (t > 32767)
                t = 32767;
            r.temperature_centi = t[15:0];
            a = tf - 128000;
            b = a * a * p6;
            b = b + ((a * p5) <<< 17);
            b = b + (p4 <<< 35);
            a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
            a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
            if (a == 0)
            begin
                r.pressure_q24_8 = '0;
                r.pressure_valid = 1'b0;
            end
            else
            begin
                p = 64'sd1048576 - $signed({44'd0, s.raw_pressure});
                num = ((p <<< 31) - b) * 3125;
                ma = num[63] ? -num : num;
                mb = a[63] ? -a : a;
                q = $signed($unsigned(ma) / $unsigned(mb));
                p = (num[63] != a[63]) ? -q : q;
                ps = p >>> 13;
                c1 = (p9 * ps * ps) >>> 25;
                c2 = (p8 * p) >>> 19;
                p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
                r.pressure_q24_8 = p[31:0];
                r.pressure_valid = 1'b1;
            end
            return r;
        endfunction

        function void set_cal(logic [1:0] idx, logic [63:0] v);
            if (idx == CFG_GROUP_A)
                grp_a = v;
            else if (idx == CFG_GROUP_B)
                grp_b = v;
            else if (idx == CFG_GROUP_C)
                grp_c = v;
        endfunction

        function void note_sample(in_item_t s);
            pending.push_back(compensate(s));
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected item %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.temperature_centi !== exp.temperature_centi)
            begin
                $display("%0t temperature exp %0d got %0d", $time,
                         exp.temperature_centi, got.temperature_centi);
                errors++;
            end
            if (got.pressure_q24_8 !== exp.pressure_q24_8)
            begin
                $display("%0t pressure exp %h got %h", $time,
                         exp.pressure_q24_8, got.pressure_q24_8);
                errors++;
            end
            if (got.pressure_valid !== exp.pressure_valid)
            begin
                $display("%0t valid exp %b got %b", $time,
                         exp.pressure_valid, got.pressure_valid);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    sample;
    logic        done;
    out_item_t   result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    comp_scoreboard sb;
    int unsigned    idle_pct;
    longint         cycles;

    pressure_temperature_compensation_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && start && !busy)
            sb.note_sample(sample);
        if (rst_n && done)
            sb.check_result(result);
        if (cycles > 2000000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_cal(logic [1:0] idx, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_cal(idx, v);
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send(logic [19:0] rt, logic [19:0] rp);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        sample <= {rt, rp};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [19:0] rand_raw();
        case ($urandom_range(5))
            0: return 20'h00000;
            1: return 20'hFFFFF;
            2: return 20'(20'h80000 + $urandom_range(16'hFFFF) - 20'h8000);
            default: return 20'($urandom_range(20'hFFFFF));
        endcase
    endfunction

    task automatic set_typical();
        write_cal(CFG_GROUP_A, {16'd36477, 16'hFFF4, 16'd26435, 16'd27504});
        write_cal(CFG_GROUP_B, {16'hFF3A, 16'd2855, 16'd3024, 16'hD6D0});
        write_cal(CFG_GROUP_C, {16'd6000, 16'hC4F8, 16'd15500, 16'hFFF9});
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset calibration gives zero divisor
        send(20'h80000, 20'h60000);
        drain();
        set_typical();
        send(20'd519888, 20'd415148);
        send(20'h00000, 20'h00000);
        send(20'hFFFFF, 20'hFFFFF);
        send(20'h00000, 20'hFFFFF);
        send(20'hFFFFF, 20'h00000);
        send(20'h55555, 20'hAAAAA);
        send(20'hAAAAA, 20'h55555);
        drain();
        // extreme calibration: saturating temperature, wrapping pressure
        write_cal(CFG_GROUP_A, {16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h0000});
        write_cal(CFG_GROUP_B, 64'h8000_8000_8000_8000);
        write_cal(CFG_GROUP_C, 64'h7FFF_7FFF_7FFF_7FFF);
        send(20'hFFFFF, 20'h12345);
        send(20'h00000, 20'h00000);
        drain();
        write_cal(CFG_GROUP_A, {16'h0000, 16'h8000, 16'h8000, 16'hFFFF});
        write_cal(CFG_GROUP_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(CFG_GROUP_C, 64'h8000_8000_8000_8000);
        send(20'hFFFFF, 20'hFFFFF);
        send(20'h00000, 20'h54321);
        send(20'h12345, 20'h00000);
        drain();
        // p1 zero gives zero divisor
        write_cal(CFG_GROUP_A, {16'h0000, 16'd0, 16'd26435, 16'd27504});
        send(20'd519888, 20'd415148);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 79;
                2: idle_pct = 0;
                default: idle_pct = 33;
            endcase
            if (ph % 3 == 0)
                set_typical();
            else
            begin
                write_cal(CFG_GROUP_A, {$urandom(), $urandom()});
                write_cal(CFG_GROUP_B, {$urandom(), $urandom()});
                write_cal(CFG_GROUP_C, {$urandom(), $urandom()});
            end
            for (int i = 0; i < 75; i++)
            begin
                if (ph % 3 == 0 && $urandom_range(3) != 0)
                    send(20'(20'd400000 + $urandom_range(200000)),
                         20'(20'd250000 + $urandom_range(300000)));
                else
                    send(rand_raw(), rand_raw());
            end
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_front.sv
rtl/ptc_mul.sv
rtl/ptc_div.sv
rtl/ptc_back.sv
rtl/pressure_temperature_compensation_top.sv
tb/tb_pressure_temperature_compensation_top.sv
